FILE: src/qsvr_pkg.sv
`default_nettype none
package qsvr_pkg;
    localparam int VW = 48;
    localparam int MW = 37;
    localparam int SW = 52;
    localparam int AW = 64;
    localparam int TW = 90;
    localparam int PLO = 24;
    localparam int SLO = 26;
    localparam logic signed [VW-1:0] OUT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] OUT_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [31:0] ONE_Q29 = 32'sh2000_0000;
    localparam logic signed [AW-1:0] HALF_Q29 = 64'sh1000_0000;
    localparam logic [3:0] REG_QW = 4'd0;
    localparam logic [3:0] REG_QX = 4'd1;
    localparam logic [3:0] REG_QY = 4'd2;
    localparam logic [3:0] REG_QZ = 4'd3;
    localparam logic [3:0] REG_AX = 4'd4;
    localparam logic [3:0] REG_AY = 4'd5;
    localparam logic [3:0] REG_AZ = 4'd6;
    typedef logic signed [MW-1:0] t_mat [3][3];

    // round a Q.58 product to Q.29, ties up
    function automatic logic signed [34:0] rnd29(input logic signed [63:0] v);
        logic signed [64:0] t;
        t = {v[63], v} + 65'sd268435456;
        return t[63:29];
    endfunction

    // clip a rounded row sum to the 48-bit output range
    function automatic logic signed [VW-1:0] sat(input logic signed [TW-30:0] v);
        if (v > (TW-29)'(OUT_MAX)) return OUT_MAX;
        if (v < (TW-29)'(OUT_MIN)) return OUT_MIN;
        return v[VW-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: src/qsvr_mat.sv
`default_nettype none
module qsvr_mat (
    input  wire                       i_clk,
    input  wire  signed [31:0]        i_w,
    input  wire  signed [31:0]        i_x,
    input  wire  signed [31:0]        i_y,
    input  wire  signed [31:0]        i_z,
    output qsvr_pkg::t_mat            o_m
);
    import qsvr_pkg::*;
    logic signed [34:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_mat r_m;

    // products, then matrix entries, both registered; user keeps config static while busy (block does not enforce it)
    always_ff @(posedge i_clk) begin
        r_xx <= rnd29(64'(i_x) * 64'(i_x));
        r_yy <= rnd29(64'(i_y) * 64'(i_y));
        r_zz <= rnd29(64'(i_z) * 64'(i_z));
        r_xy <= rnd29(64'(i_x) * 64'(i_y));
        r_xz <= rnd29(64'(i_x) * 64'(i_z));
        r_yz <= rnd29(64'(i_y) * 64'(i_z));
        r_wx <= rnd29(64'(i_w) * 64'(i_x));
        r_wy <= rnd29(64'(i_w) * 64'(i_y));
        r_wz <= rnd29(64'(i_w) * 64'(i_z));
        r_m[0][0] <= MW'(ONE_Q29) - ((MW'(r_yy) + MW'(r_zz)) <<< 1);
        r_m[0][1] <= (MW'(r_xy) - MW'(r_wz)) <<< 1;
        r_m[0][2] <= (MW'(r_xz) + MW'(r_wy)) <<< 1;
        r_m[1][0] <= (MW'(r_xy) + MW'(r_wz)) <<< 1;
        r_m[1][1] <= MW'(ONE_Q29) - ((MW'(r_xx) + MW'(r_zz)) <<< 1);
        r_m[1][2] <= (MW'(r_yz) - MW'(r_wx)) <<< 1;
        r_m[2][0] <= (MW'(r_xz) - MW'(r_wy)) <<< 1;
        r_m[2][1] <= (MW'(r_yz) + MW'(r_wx)) <<< 1;
        r_m[2][2] <= MW'(ONE_Q29) - ((MW'(r_xx) + MW'(r_yy)) <<< 1);
    end
    assign o_m = r_m;
endmodule
`default_nettype wire

FILE: src/quaternion_state_vector_rotate.sv
`default_nettype none
// channel      | dir | tdata fields (lsb up)                              | tuser
// s_axis       | in  | pos_x pos_y pos_z vel_x vel_y vel_z (288 bits)     | cmd
// m_axis       | out | rot_pos_x/y/z rot_vel_x/y/z (288 bits)             | none
// cfg          | in  | i_cfg_we, i_cfg_idx (0..6), i_cfg_data 32 bits     |
// one transfer per cycle sustained while the output is empty or m_axis_tready is high; eight register stages
// stages: input, s*p partial products, partial sums, s*p+v, r partial products,
// partial sums, recombine/round/saturate, output
// operands split in high and low parts, so no multiplier exceeds about 37 by 27
// stall freezes the whole pipe (global enable), so nothing is lost or repeated
// matrix is rebuilt from registers via registered products, then registered entries; config only while idle
// synchronous active-low reset clears valid bits, sets config to identity quaternion and zero spin
module quaternion_state_vector_rotate (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [3:0]   i_cfg_idx,
    input  wire  [31:0]  i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [287:0] s_axis_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  wire          s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [287:0] m_axis_tdata   // rot_pos_x..z, rot_vel_x..z
);
    import qsvr_pkg::*;
    localparam int NS = 8;

    logic signed [31:0] r_q [4];
    logic signed [31:0] r_av [3];
    logic signed [32:0] c_sp [3][2];    // skew coefficients with the sign folded in
    logic signed [VW-1:0] x_sp [3][2];  // position component for each coefficient
    t_mat m;
    logic en;
    logic [NS-1:0] r_v;

    // stage registers
    logic r1_cmd, r2_cmd, r3_cmd, r4_cmd, r5_cmd, r6_cmd;
    logic signed [VW-1:0] r1_p [3], r1_vv [3], r2_p [3], r2_vv [3];
    logic signed [VW-1:0] r3_p [3], r3_vv [3], r4_p [3];
    logic signed [AW-1:0] r2_ph [3][2], r2_pl [3][2];
    logic signed [AW-1:0] r3_h [3], r3_l [3];
    logic signed [SW-1:0] r4_s [3];
    logic signed [AW-1:0] r5_ph [3][3], r5_pl [3][3], r5_vh [3][3], r5_vl [3][3];
    logic signed [AW-1:0] r6_ph [3], r6_pl [3], r6_vh [3], r6_vl [3];
    logic signed [VW-1:0] r7_o [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0] <= ONE_Q29;
            r_q[1] <= '0; r_q[2] <= '0; r_q[3] <= '0;
            r_av[0] <= '0; r_av[1] <= '0; r_av[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QW: r_q[0] <= i_cfg_data;
                REG_QX: r_q[1] <= i_cfg_data;
                REG_QY: r_q[2] <= i_cfg_data;
                REG_QZ: r_q[3] <= i_cfg_data;
                REG_AX: r_av[0] <= i_cfg_data;
                REG_AY: r_av[1] <= i_cfg_data;
                REG_AZ: r_av[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qsvr_mat u_mat (.i_clk(i_clk), .i_w(r_q[0]), .i_x(r_q[1]), .i_y(r_q[2]),
                    .i_z(r_q[3]), .o_m(m));

    // rows of the transposed skew matrix, zero terms dropped
    always_comb begin
        c_sp[0][0] = 33'(r_av[2]);  x_sp[0][0] = r1_p[1];
        c_sp[0][1] = -33'(r_av[1]); x_sp[0][1] = r1_p[2];
        c_sp[1][0] = -33'(r_av[2]); x_sp[1][0] = r1_p[0];
        c_sp[1][1] = 33'(r_av[0]);  x_sp[1][1] = r1_p[2];
        c_sp[2][0] = 33'(r_av[1]);  x_sp[2][0] = r1_p[0];
        c_sp[2][1] = -33'(r_av[0]); x_sp[2][1] = r1_p[1];
    end

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[NS-2:0], s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: capture input
            r1_cmd <= s_axis_tuser;
            for (int i = 0; i < 3; i++) begin
                r1_p[i]  <= s_axis_tdata[i*VW +: VW];
                r1_vv[i] <= s_axis_tdata[(i+3)*VW +: VW];
            end
            // stage 2: s*p partial products, position split at bit 24
            r2_cmd <= r1_cmd; r2_p <= r1_p; r2_vv <= r1_vv;
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 2; k++) begin
                    r2_ph[i][k] <= AW'(c_sp[i][k]) * AW'($signed(x_sp[i][k][VW-1:PLO]));
                    r2_pl[i][k] <= AW'(c_sp[i][k])
                                   * AW'($signed({1'b0, x_sp[i][k][PLO-1:0]}));
                end
            // stage 3: row sums of the high and low parts, rounding half on the low side
            r3_cmd <= r2_cmd; r3_p <= r2_p; r3_vv <= r2_vv;
            for (int i = 0; i < 3; i++) begin
                r3_h[i] <= r2_ph[i][0] + r2_ph[i][1];
                r3_l[i] <= r2_pl[i][0] + r2_pl[i][1] + HALF_Q29;
            end
            // stage 4: recombine, round to q.16, add velocity (kept unclipped)
            r4_cmd <= r3_cmd; r4_p <= r3_p;
            for (int i = 0; i < 3; i++)
                r4_s[i] <= SW'(((TW'(r3_h[i]) <<< PLO) + TW'(r3_l[i])) >>> 29)
                           + SW'(r3_vv[i]);
            // stage 5: matrix partial products
            r5_cmd <= r4_cmd;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    r5_ph[i][j] <= AW'(m[i][j]) * AW'($signed(r4_p[j][VW-1:PLO]));
                    r5_pl[i][j] <= AW'(m[i][j]) * AW'($signed({1'b0, r4_p[j][PLO-1:0]}));
                    r5_vh[i][j] <= AW'(m[i][j]) * AW'($signed(r4_s[j][SW-1:SLO]));
                    r5_vl[i][j] <= AW'(m[i][j]) * AW'($signed({1'b0, r4_s[j][SLO-1:0]}));
                end
            // stage 6: row sums of the partial products
            r6_cmd <= r5_cmd;
            for (int i = 0; i < 3; i++) begin
                r6_ph[i] <= r5_ph[i][0] + r5_ph[i][1] + r5_ph[i][2];
                r6_pl[i] <= r5_pl[i][0] + r5_pl[i][1] + r5_pl[i][2] + HALF_Q29;
                r6_vh[i] <= r5_vh[i][0] + r5_vh[i][1] + r5_vh[i][2];
                r6_vl[i] <= r5_vl[i][0] + r5_vl[i][1] + r5_vl[i][2] + HALF_Q29;
            end
            // stage 7: recombine, round, saturate; velocity is zero for position only
            for (int i = 0; i < 3; i++) begin
                r7_o[i] <= sat((TW-29)'(((TW'(r6_ph[i]) <<< PLO) + TW'(r6_pl[i])) >>> 29));
                r7_o[i+3] <= r6_cmd
                    ? sat((TW-29)'(((TW'(r6_vh[i]) <<< SLO) + TW'(r6_vl[i])) >>> 29))
                    : '0;
            end
            // stage 8: output register
            for (int i = 0; i < 6; i++)
                m_axis_tdata[i*VW +: VW] <= r7_o[i];
        end
    end
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

// checks the quaternion rotation pipe against a fixed-point predictor of its own:
// directed extremes first, then random state vectors under several rotation and
// angular-velocity settings, with random idle on the input and random stall on the output

import qsvr_pkg::*;

// holds the register copy and the queue of expected rotated state vectors
class rotation_scoreboard;
    longint               cfg_val[7];
    logic [287:0]         expected_rot[$];
    int                   mismatches;
    int                   reported;

    function new();
        for (int i = 0; i < 7; i++) cfg_val[i] = 0;
        cfg_val[REG_QW] = longint'(ONE_Q29);
        mismatches = 0;
        reported = 0;
    endfunction

    function void set_reg(logic [3:0] idx, logic [31:0] val);
        cfg_val[idx] = longint'($signed(val));
    endfunction

    // q.58 product to q.29, nearest with ties up
    function longint round29(longint v);
        return (v + 64'sd268435456) >>> 29;
    endfunction

    // three products summed exactly, then rounded down by 29 bits
    function longint dot3(longint c0, longint c1, longint c2,
                          longint a0, longint a1, longint a2);
        logic signed [127:0] s;
        s = 128'(c0) * 128'(a0);
        s = s + 128'(c1) * 128'(a1);
        s = s + 128'(c2) * 128'(a2) + 128'sd268435456;
        s = s >>> 29;
        return longint'(s[63:0]);
    endfunction

    function logic [47:0] sat48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    // an accepted input: work out the rotated position and velocity
    function void note_input(bit cmd, logic [287:0] data);
        longint w, x, y, z, ax, ay, az;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint m[3][3];
        longint p[3], v[3], sp[3];
        logic [287:0] res;
        w = cfg_val[0]; x = cfg_val[1]; y = cfg_val[2]; z = cfg_val[3];
        ax = cfg_val[4]; ay = cfg_val[5]; az = cfg_val[6];
        xx = round29(x * x); yy = round29(y * y); zz = round29(z * z);
        xy = round29(x * y); xz = round29(x * z); yz = round29(y * z);
        wx = round29(w * x); wy = round29(w * y); wz = round29(w * z);
        m[0][0] = (64'sd1 <<< 29) - 2 * (yy + zz);
        m[0][1] = 2 * (xy - wz);
        m[0][2] = 2 * (xz + wy);
        m[1][0] = 2 * (xy + wz);
        m[1][1] = (64'sd1 <<< 29) - 2 * (xx + zz);
        m[1][2] = 2 * (yz - wx);
        m[2][0] = 2 * (xz - wy);
        m[2][1] = 2 * (yz + wx);
        m[2][2] = (64'sd1 <<< 29) - 2 * (xx + yy);
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(data[48*i +: 48]));
            v[i] = longint'($signed(data[48*(i+3) +: 48]));
        end
        res = '0;
        for (int i = 0; i < 3; i++)
            res[48*i +: 48] = sat48(dot3(m[i][0], m[i][1], m[i][2], p[0], p[1], p[2]));
        if (cmd) begin
            // velocity term: v plus transposed skew of omega times p, kept unclipped
            sp[0] = dot3(0, az, -ay, p[0], p[1], p[2]) + v[0];
            sp[1] = dot3(-az, 0, ax, p[0], p[1], p[2]) + v[1];
            sp[2] = dot3(ay, -ax, 0, p[0], p[1], p[2]) + v[2];
            for (int i = 0; i < 3; i++)
                res[48*(i+3) +: 48] =
                    sat48(dot3(m[i][0], m[i][1], m[i][2], sp[0], sp[1], sp[2]));
        end
        expected_rot.push_back(res);
    endfunction

    function void check_result(logic [287:0] got);
        logic [287:0] exp_v;
        bit bad;
        if (expected_rot.size() == 0) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                $display("unexpected output transfer %h", got);
            end
            return;
        end
        exp_v = expected_rot.pop_front();
        bad = 0;
        for (int i = 0; i < 6; i++)
            if (got[48*i +: 48] !== exp_v[48*i +: 48]) bad = 1;
        if (bad) begin
            mismatches++;
            if (reported < 10) begin
                reported++;
                for (int i = 0; i < 6; i++)
                    if (got[48*i +: 48] !== exp_v[48*i +: 48])
                        $display("field %0d: expected %h, got %h",
                                 i, exp_v[48*i +: 48], got[48*i +: 48]);
            end
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [3:0]    i_cfg_idx = REG_QW;
    logic [31:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    wire           s_axis_tready;
    logic [287:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    wire           m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    wire  [287:0]  m_axis_tdata;

    rotation_scoreboard sb = new();
    int  cycle_count = 0;
    bit  no_idle = 0;      // stretches with back-to-back transfers on both sides

    always #4 i_clk = ~i_clk;

    quaternion_state_vector_rotate DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // output side: check each transfer, then choose the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (no_idle)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70)
                             || ($urandom_range(0, 29) == 0 ? 1'b0 : m_axis_tready);
    end

    // one input transfer, with a random idle gap in front
    task automatic send_vec(bit cmd, logic [47:0] p[3], logic [47:0] v[3]);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {v[2], v[1], v[0], p[2], p[1], p[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(cmd, {v[2], v[1], v[0], p[2], p[1], p[0]});
    endtask

    // registers change only with the pipe drained
    task automatic write_cfg(logic [31:0] vals[7]);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_rot.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int i = 0; i < 7; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 4'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(4'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
        // wait for the matrix rebuild
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 48'({$urandom(), $urandom()});
        if (r < 7) return 48'($signed($urandom_range(0, 2000000)) - 1000000) <<< 8;
        if (r == 7) return 48'h7FFF_FFFF_FFFF;
        if (r == 8) return 48'h8000_0000_0000;
        return 48'($signed(16'($urandom())));
    endfunction

    function automatic logic [31:0] rand32();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
        if (r == 5) return 32'h7FFF_FFFF;
        if (r == 6) return 32'h8000_0000;
        if (r == 7) return '0;
        return $urandom();
    endfunction

    task automatic random_items(int count);
        logic [47:0] p[3], v[3];
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
            for (int i = 0; i < 3; i++) begin
                p[i] = rand48();
                v[i] = rand48();
            end
            send_vec(1'($urandom_range(0, 1)), p, v);
        end
        no_idle = 0;
    endtask

    initial begin
        logic [47:0] p[3], v[3];
        logic [31:0] cfg[7];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, identity quaternion after reset
        p = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0};
        v = '{48'h1_0000, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF};
        send_vec(0, p, v);   // position only: velocity inputs ignored
        send_vec(1, p, v);
        p = '{48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000};
        send_vec(1, p, p);
        p = '{48'h0, 48'h0, 48'h0};
        send_vec(1, p, p);

        // directed, extreme (non-unit) quaternion and angular velocity: saturation
        cfg = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        write_cfg(cfg);
        p = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF};
        v = '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h1};
        send_vec(0, p, v);
        send_vec(1, p, v);
        p = '{48'h1_0000, 48'hFFFF_FFFF_0000, 48'h8000};
        send_vec(1, p, v);
        cfg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        write_cfg(cfg);
        send_vec(1, p, v);
        p = '{48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF};
        send_vec(1, p, p);
        send_vec(0, p, p);

        // 90 degrees about z with a small spin (rounding ties)
        cfg = '{32'h16A0_9E66, 32'h0, 32'h0, 32'h16A0_9E66,
                32'h0, 32'h0, 32'h0100_0000};
        write_cfg(cfg);
        p = '{48'h1, 48'hFFFF_FFFF_FFFF, 48'h3};
        send_vec(1, p, p);
        random_items(250);

        // random phases, a few with extremes in the registers
        for (int ph = 0; ph < 5; ph++) begin
            for (int i = 0; i < 7; i++) cfg[i] = rand32();
            write_cfg(cfg);
            random_items(250);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_rot.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_rot.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
